>>> rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and constants shared by the max-heap priority queue and its cells
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 7;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        opcode_t                    opcode;
        logic signed [DATA_W-1:0]   value;
    } item_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0]   removed_value;
        status_t                    status;
        logic [COUNT_W-1:0]         count;
    } result_t;

    // broadcast to every cell for one transaction
    typedef struct packed
    {
        logic                       ins;
        logic                       rem;
        logic signed [DATA_W-1:0]   value;
    } cell_ctrl_t;

    // what a cell shows its neighbours
    typedef struct packed
    {
        logic                       valid;
        logic signed [DATA_W-1:0]   value;
        logic                       gt;
    } cell_link_t;

endpackage

>>> rtl/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Priority queue of signed 32-bit values returning the maximum on remove
// ----------------------------------------------------------------------------
// the result is registered and is on result with done in the cycle after the transaction
// throughput: one transaction per cycle, busy never rises
// each cell compares the new value with its own entry once, set by one compare
// reset empties the queue at once; the receiver cannot stall, so done is
// a single-cycle strobe
// ----------------------------------------------------------------------------
module max_heap_priority_queue
#(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mhpq_pkg::item_t   item,
    output logic              done,
    output mhpq_pkg::result_t result
);

    localparam int CW = $clog2(CAPACITY + 1);

    mhpq_pkg::cell_ctrl_t ctrl;
    mhpq_pkg::cell_link_t link [CAPACITY];
    mhpq_pkg::cell_link_t prev_link [CAPACITY];
    mhpq_pkg::cell_link_t next_link [CAPACITY];

    logic                    accept;
    logic                    full;
    logic                    empty;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [CW+mhpq_pkg::COUNT_W-1:0] count_ext;
    logic                    done_reg;
    mhpq_pkg::result_t       result_reg;
    mhpq_pkg::result_t       result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);

    assign ctrl.ins   = accept && (item.opcode == mhpq_pkg::OP_INSERT) && !full;
    assign ctrl.rem   = accept && (item.opcode == mhpq_pkg::OP_REMOVE) && !empty;
    assign ctrl.value = item.value;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign prev_link[i] = '0;
            end
            else
            begin : g_mid
                assign prev_link[i] = link[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign next_link[i] = '0;
            end
            else
            begin : g_rest
                assign next_link[i] = link[i+1];
            end

            mhpq_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .prev  (prev_link[i]),
                .next  (next_link[i]),
                .link  (link[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_ext = {{mhpq_pkg::COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        result_next.removed_value = '0;
        result_next.status        = mhpq_pkg::STATUS_DONE;
        result_next.count         = count_ext[mhpq_pkg::COUNT_W-1:0];
        if (item.opcode == mhpq_pkg::OP_INSERT)
        begin
            if (full)
            begin
                result_next.status = mhpq_pkg::STATUS_FULL;
            end
        end
        else if (empty)
        begin
            result_next.status = mhpq_pkg::STATUS_EMPTY;
        end
        else
        begin
            result_next.removed_value = link[0].value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every result comes from a transaction in the previous cycle
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without a transaction");

    // the head slot is occupied exactly when the queue is not empty
    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        link[0].valid == (count_reg != '0))
        else $error("head slot disagrees with count");

    // an empty status only reports an empty queue
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == mhpq_pkg::STATUS_EMPTY) |-> (count_reg == '0))
        else $error("empty status with entries stored");

    // a full status only reports a full queue
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == mhpq_pkg::STATUS_FULL) |-> full)
        else $error("full status below capacity");

    generate
        for (i = 1; i < CAPACITY; i++)
        begin : g_order
            // occupied slots are packed at the head and kept in descending order
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                link[i].valid |-> (link[i-1].valid && (link[i-1].value >= link[i].value)))
                else $error("row out of order");
        end
    endgenerate

endmodule

>>> rtl/mhpq_cell.sv
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted row: holds one entry, largest entries towards slot 0
// ----------------------------------------------------------------------------
module mhpq_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mhpq_pkg::cell_ctrl_t ctrl,
    input  mhpq_pkg::cell_link_t prev,
    input  mhpq_pkg::cell_link_t next,
    output mhpq_pkg::cell_link_t link
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [mhpq_pkg::DATA_W-1:0] value_reg;
    logic signed [mhpq_pkg::DATA_W-1:0] value_next;
    logic                               gt;

    // new value belongs at or above this slot
    assign gt = !valid_reg || (ctrl.value > value_reg);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.rem)
        begin
            valid_next = next.valid;
            value_next = next.value;
        end
        else if (ctrl.ins)
        begin
            if (prev.gt)
            begin
                valid_next = prev.valid;
                value_next = prev.value;
            end
            else if (gt)
            begin
                valid_next = 1'b1;
                value_next = ctrl.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.value = value_reg;
    assign link.gt    = gt;

endmodule

>>> tb/max_heap_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Self-checking bench for the max-heap priority queue: a directed opening of
// extreme values, ties and empty removes, then random fill, drain and mixed
// runs that reach the full and empty states. A behavioural heap predicts
// every result, and a monitor compares each strobed result field by field.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;

    import mhpq_pkg::*;

    localparam int QUEUE_DEPTH    = CAPACITY_DEF;
    localparam int RANDOM_ITEMS   = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic    clk;
    logic    rst_n;
    logic    start = 1'b0;
    logic    busy;
    item_t   item = '0;
    logic    done;
    result_t result;

    item_t   pending_items[$];
    result_t expected_results[$];

    logic signed [DATA_W-1:0] heap_model [QUEUE_DEPTH];
    int heap_fill;

    int error_count;
    int items_sent;
    int total_items;
    int idle_cycles;

    max_heap_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // behavioural heap: insert sifts up, remove sifts down from the root
    function automatic result_t heap_predict(input item_t it);
        result_t                  res;
        int                       pos;
        int                       up;
        int                       lc;
        int                       rc;
        int                       best;
        logic                     settled;
        logic signed [DATA_W-1:0] tmp;
        res = '0;
        res.status = STATUS_DONE;
        if (it.opcode == OP_INSERT)
        begin
            if (heap_fill >= QUEUE_DEPTH)
                res.status = STATUS_FULL;
            else
            begin
                pos = heap_fill;
                heap_model[pos] = it.value;
                heap_fill++;
                settled = 1'b0;
                while (pos > 0 && !settled)
                begin
                    up = (pos - 1) / 2;
                    if (heap_model[up] < heap_model[pos])
                    begin
                        tmp = heap_model[up];
                        heap_model[up] = heap_model[pos];
                        heap_model[pos] = tmp;
                        pos = up;
                    end
                    else
                        settled = 1'b1;
                end
            end
        end
        else
        begin
            if (heap_fill == 0)
                res.status = STATUS_EMPTY;
            else
            begin
                res.removed_value = heap_model[0];
                heap_model[0] = heap_model[heap_fill - 1];
                heap_fill--;
                pos = 0;
                settled = 1'b0;
                while (!settled)
                begin
                    lc = 2 * pos + 1;
                    rc = 2 * pos + 2;
                    best = pos;
                    if (lc < heap_fill && heap_model[lc] > heap_model[pos])
                        best = lc;
                    if (rc < heap_fill && heap_model[rc] > heap_model[best])
                        best = rc;
                    if (best == pos)
                        settled = 1'b1;
                    else
                    begin
                        tmp = heap_model[pos];
                        heap_model[pos] = heap_model[best];
                        heap_model[best] = tmp;
                        pos = best;
                    end
                end
            end
        end
        res.count = heap_fill[COUNT_W-1:0];
        return res;
    endfunction

    // biased towards extremes and a narrow band that produces ties
    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(9, 0))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2, 3:    v = $signed($urandom_range(7, 0)) - 4;
            4:       v = 32'sh8000_0000 + $urandom_range(3, 0);
            5:       v = 32'sh7fff_ffff - $urandom_range(3, 0);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_item(input opcode_t op, input logic signed [DATA_W-1:0] v);
        item_t it;
        it.opcode = op;
        it.value  = v;
        pending_items.push_back(it);
    endtask

    task automatic queue_run(input int len, input int insert_pct);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99, 0) < insert_pct)
                queue_item(OP_INSERT, pick_value());
            else
                queue_item(OP_REMOVE, $urandom);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        int idle_pct;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.push_back(heap_predict(item));
                items_sent++;
            end
            if (!start || !busy)
            begin
                if (items_sent < total_items / 3)
                    idle_pct = 29;
                else if (items_sent < (2 * total_items) / 3)
                    idle_pct = 79;
                else
                    idle_pct = 0;
                if (pending_items.size() != 0 && $urandom_range(99, 0) >= idle_pct)
                begin
                    start <= 1'b1;
                    item  <= pending_items.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (result.removed_value !== exp_res.removed_value)
                begin
                    $display("%0t: removed_value mismatch, expected %0d, actual %0d",
                             $time, exp_res.removed_value, result.removed_value);
                    error_count++;
                end
                if (result.status !== exp_res.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_res.status, result.status);
                    error_count++;
                end
                if (result.count !== exp_res.count)
                begin
                    $display("%0t: count mismatch, expected %0d, actual %0d",
                             $time, exp_res.count, result.count);
                    error_count++;
                end
            end
        end
    end

    // cycles without any transaction in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        heap_fill   = 0;
        error_count = 0;
        items_sent  = 0;
        idle_cycles = 0;
        total_items = 0;

        // directed: empty remove, extremes, ties, drain back to empty
        queue_item(OP_REMOVE, 32'sh7fff_ffff);
        queue_item(OP_INSERT, 32'sh0000_0000);
        queue_item(OP_REMOVE, 32'sh0000_0000);
        queue_item(OP_REMOVE, 32'sh0000_0000);
        queue_item(OP_INSERT, 32'sh8000_0000);
        queue_item(OP_INSERT, 32'sh7fff_ffff);
        queue_item(OP_INSERT, -32'sd1);
        queue_item(OP_INSERT, 32'sh0000_0001);
        queue_item(OP_INSERT, 32'sh7fff_ffff);
        queue_item(OP_INSERT, 32'sh8000_0000);
        queue_item(OP_INSERT, 32'sh0000_0005);
        queue_item(OP_INSERT, 32'sh0000_0005);
        queue_item(OP_INSERT, 32'sh0000_0005);
        queue_item(OP_INSERT, 32'sh5555_5555);
        queue_item(OP_INSERT, 32'shaaaa_aaaa);
        for (int i = 0; i < 12; i++)
            queue_item(OP_REMOVE, 32'shffff_ffff);

        // random: a full fill and drain first, then assorted runs
        queue_run(QUEUE_DEPTH + 4, 100);
        queue_run(QUEUE_DEPTH + 4, 0);
        while (pending_items.size() < RANDOM_ITEMS + 27)
        begin
            case ($urandom_range(3, 0))
                0:       queue_run($urandom_range(70, 30), 100);
                1:       queue_run($urandom_range(70, 10), 0);
                2:       queue_run($urandom_range(40, 20), 60);
                default: queue_run($urandom_range(40, 20), 40);
            endcase
        end
        total_items = pending_items.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
